// ----- rtl/tas_pkg.sv -----
package tas_pkg;

   // Field widths of the channels.
   localparam int MILLI_W   = 18;
   localparam int DEG_W     = 9;
   localparam int CSR_IDX_W = 4;

   // Limit register file.
   localparam int LIMIT_COUNT = 8;
   localparam int LIMIT_IDX_W = 3;

   localparam logic [LIMIT_IDX_W-1:0] LIM_DIGITAL_WARN = 3'd0;
   localparam logic [LIMIT_IDX_W-1:0] LIM_DIGITAL_CRIT = 3'd1;
   localparam logic [LIMIT_IDX_W-1:0] LIM_RF_WARN      = 3'd2;
   localparam logic [LIMIT_IDX_W-1:0] LIM_RF_CRIT      = 3'd3;
   localparam logic [LIMIT_IDX_W-1:0] LIM_PA_WARN      = 3'd4;
   localparam logic [LIMIT_IDX_W-1:0] LIM_PA_CRIT      = 3'd5;
   localparam logic [LIMIT_IDX_W-1:0] LIM_BOARD_WARN   = 3'd6;
   localparam logic [LIMIT_IDX_W-1:0] LIM_BOARD_CRIT   = 3'd7;

   localparam logic [MILLI_W-1:0] MILLI_PER_DEG = 18'd1000;

   typedef logic [LIMIT_COUNT-1:0][DEG_W-1:0] limit_array_type;

   // Warning limits reset to 70 degrees, critical limits to 85 degrees.
   localparam limit_array_type LIMIT_RESET = {
      9'd85, 9'd70, 9'd85, 9'd70, 9'd85, 9'd70, 9'd85, 9'd70
   };

   typedef enum logic [1:0] {
      ST_NORMAL   = 2'd0,
      ST_HYST     = 2'd1,
      ST_WARNING  = 2'd2,
      ST_CRITICAL = 2'd3
   } thermal_state_type;

   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_NORMAL   = 2'd1,
      ACT_WARNING  = 2'd2,
      ACT_CRITICAL = 2'd3
   } action_kind_type;

   typedef enum logic [1:0] {
      ALERT_NONE     = 2'd0,
      ALERT_WARNING  = 2'd1,
      ALERT_CRITICAL = 2'd2
   } alert_kind_type;

   // One check request as held in the input register.
   typedef struct packed {
      logic [MILLI_W-1:0]      digital_millideg;
      logic                    digital_fail;
      logic [MILLI_W-1:0]      rf_millideg;
      logic                    rf_fail;
      logic                    aux_present;
      logic                    aux_fail;
      logic signed [DEG_W-1:0] pa_degrees;
      logic signed [DEG_W-1:0] board_degrees;
   } req_payload_type;

   // One result as held in the output register.
   typedef struct packed {
      thermal_state_type thermal_state;
      logic              state_changed;
      action_kind_type   action_kind;
      alert_kind_type    alert_kind;
   } rsp_payload_type;

   // Warning and critical conditions raised by one check.
   typedef struct packed {
      logic warn;
      logic crit;
   } cond_type;

   // True when the reading, truncated to whole degrees, lies strictly above the limit.
   // floor(m / 1000) > lim holds exactly when m >= (lim + 1) * 1000, and always
   // for a negative limit since the reading is never negative.
   function automatic logic above_milli(logic [MILLI_W-1:0] m,
                                        logic signed [DEG_W-1:0] lim);
      logic [DEG_W-1:0]   steps;
      logic [MILLI_W-1:0] thr;
      steps = lim + 9'd1;
      thr   = MILLI_W'({{(MILLI_W-DEG_W){1'b0}}, steps} * MILLI_PER_DEG);
      return lim[DEG_W-1] | (m >= thr);
   endfunction

endpackage

// ----- rtl/tas_intf.sv -----
// Check request channel.
interface tas_req_if import tas_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [MILLI_W-1:0]      digital_millideg;
   logic                    digital_fail;
   logic [MILLI_W-1:0]      rf_millideg;
   logic                    rf_fail;
   logic                    aux_present;
   logic                    aux_fail;
   logic signed [DEG_W-1:0] pa_degrees;
   logic signed [DEG_W-1:0] board_degrees;

   modport source (output valid, digital_millideg, digital_fail, rf_millideg, rf_fail,
                   aux_present, aux_fail, pa_degrees, board_degrees, input ready);
   modport sink (input valid, digital_millideg, digital_fail, rf_millideg, rf_fail,
                 aux_present, aux_fail, pa_degrees, board_degrees, output ready);
endinterface

// Result channel.
interface tas_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] thermal_state;
   logic       state_changed;
   logic [1:0] action_kind;
   logic [1:0] alert_kind;

   modport source (output valid, thermal_state, state_changed, action_kind, alert_kind,
                   input ready);
   modport sink (input valid, thermal_state, state_changed, action_kind, alert_kind,
                 output ready);
endinterface

// Limit register write channel.
interface tas_csr_if import tas_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DEG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/thermal_alarm_state_machine.sv -----
// A request accepted from the channel is held in the input register and its result
// reaches the port through the result register. Throughput: one check request per
// cycle while the result channel takes results; the state update is combinational
// between the input register and the result register. Reset (synchronous, active
// high) empties both registers, puts the machine in the normal state and loads the
// warning limits with 70 and the critical limits with 85 degrees.
module thermal_alarm_state_machine import tas_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   tas_req_if.sink   req_chan,
   tas_rsp_if.source rsp_chan,
   tas_csr_if.sink   csr_chan
);

   req_payload_type   req_ff;
   logic              req_valid_ff;
   rsp_payload_type   rsp_ff;
   rsp_payload_type   rsp_in;
   logic              rsp_valid_ff;
   thermal_state_type state_ff;
   thermal_state_type state_in;
   limit_array_type   limits_ff;
   cond_type          cond;
   req_payload_type   req_payload;
   logic              req_fire;
   logic              out_free;
   logic              move;

   // Handshake control: the input register drains whenever the result register frees up.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign move           = req_valid_ff && out_free;
   assign req_chan.ready = !req_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign req_payload.digital_millideg = req_chan.digital_millideg;
   assign req_payload.digital_fail     = req_chan.digital_fail;
   assign req_payload.rf_millideg      = req_chan.rf_millideg;
   assign req_payload.rf_fail          = req_chan.rf_fail;
   assign req_payload.aux_present      = req_chan.aux_present;
   assign req_payload.aux_fail         = req_chan.aux_fail;
   assign req_payload.pa_degrees       = req_chan.pa_degrees;
   assign req_payload.board_degrees    = req_chan.board_degrees;

   // Limit comparisons on the registered request.
   tas_eval u_eval (
      .req    (req_ff),
      .limits (limits_ff),
      .cond   (cond)
   );

   // Next state and result fields.
   always_comb begin
      thermal_state_type nxt;
      logic              changed;
      nxt     = state_ff;
      changed = 1'b1;
      case (state_ff)
         ST_NORMAL: begin
            if (cond.crit) nxt = ST_CRITICAL;
            else if (cond.warn) nxt = ST_WARNING;
            else changed = 1'b0;
         end
         ST_HYST: begin
            if (cond.crit) nxt = ST_CRITICAL;
            else if (cond.warn) nxt = ST_WARNING;
            else nxt = ST_NORMAL;
         end
         ST_WARNING: begin
            if (cond.crit) nxt = ST_CRITICAL;
            else if (!cond.warn) nxt = ST_HYST;
            else changed = 1'b0;
         end
         ST_CRITICAL: begin
            if (!cond.crit && !cond.warn) nxt = ST_WARNING;
            else changed = 1'b0;
         end
         default: begin
            nxt = ST_NORMAL;
         end
      endcase

      rsp_in.thermal_state = nxt;
      rsp_in.state_changed = changed;
      rsp_in.action_kind   = ACT_NONE;
      rsp_in.alert_kind    = ALERT_NONE;
      if (changed) begin
         case (nxt)
            ST_NORMAL: begin
               rsp_in.action_kind = ACT_NORMAL;
            end
            ST_WARNING: begin
               rsp_in.action_kind = ACT_WARNING;
               rsp_in.alert_kind  = ALERT_WARNING;
            end
            ST_CRITICAL: begin
               rsp_in.action_kind = ACT_CRITICAL;
               rsp_in.alert_kind  = ALERT_CRITICAL;
            end
            default: begin
               rsp_in.action_kind = ACT_NONE;
            end
         endcase
      end

      state_in = move ? nxt : state_ff;
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NORMAL;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pipeline valid bits and limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limits_ff    <= LIMIT_RESET;
      end else begin
         req_valid_ff <= req_fire || (req_valid_ff && !move);
         rsp_valid_ff <= move || (rsp_valid_ff && !rsp_chan.ready);
         if (csr_chan.valid && csr_chan.index < CSR_IDX_W'(LIMIT_COUNT)) begin
            limits_ff[csr_chan.index[LIMIT_IDX_W-1:0]] <= csr_chan.data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_payload;
      end
      if (move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.thermal_state = rsp_ff.thermal_state;
   assign rsp_chan.state_changed = rsp_ff.state_changed;
   assign rsp_chan.action_kind   = rsp_ff.action_kind;
   assign rsp_chan.alert_kind    = rsp_ff.alert_kind;

   // A request never lands on a held request that is not leaving.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !move |-> !req_fire)
      else $error("request accepted over a stalled request");

   // The reported state is the state the machine moved to.
   a_state_matches: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_ff.thermal_state == state_ff)
      else $error("result state differs from machine state");

   // Without a state change no action or alert is raised.
   a_quiet_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.state_changed |->
         rsp_ff.action_kind == ACT_NONE && rsp_ff.alert_kind == ALERT_NONE)
      else $error("action or alert without state change");

   // On a change, only entering hysteresis carries no action.
   a_hyst_no_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.state_changed |->
         (rsp_ff.action_kind == ACT_NONE) == (rsp_ff.thermal_state == ST_HYST))
      else $error("action does not match new state");

endmodule

// ----- rtl/tas_eval.sv -----
module tas_eval import tas_pkg::*; (
   input  req_payload_type req,
   input  limit_array_type limits,
   output cond_type        cond
);

   // Compare every reading against its limit pair; a failed read raises both conditions.
   always_comb begin
      cond = '0;

      if (req.digital_fail) begin
         cond.warn = 1'b1;
         cond.crit = 1'b1;
      end else begin
         cond.warn = cond.warn |
                     above_milli(req.digital_millideg, $signed(limits[LIM_DIGITAL_WARN]));
         cond.crit = cond.crit |
                     above_milli(req.digital_millideg, $signed(limits[LIM_DIGITAL_CRIT]));
      end

      if (req.rf_fail) begin
         cond.warn = 1'b1;
         cond.crit = 1'b1;
      end else begin
         cond.warn = cond.warn | above_milli(req.rf_millideg, $signed(limits[LIM_RF_WARN]));
         cond.crit = cond.crit | above_milli(req.rf_millideg, $signed(limits[LIM_RF_CRIT]));
      end

      // PA and board readings only count when present in this check.
      if (req.aux_present) begin
         if (req.aux_fail) begin
            cond.warn = 1'b1;
            cond.crit = 1'b1;
         end else begin
            cond.warn = cond.warn |
                        (req.pa_degrees > $signed(limits[LIM_PA_WARN])) |
                        (req.board_degrees > $signed(limits[LIM_BOARD_WARN]));
            cond.crit = cond.crit |
                        (req.pa_degrees > $signed(limits[LIM_PA_CRIT])) |
                        (req.board_degrees > $signed(limits[LIM_BOARD_CRIT]));
         end
      end
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import tas_pkg::*;

   localparam int CLOCK_HALF       = 4;
   localparam int RESET_CYCLES     = 8;
   localparam int RESULT_LATENCY   = 2;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int HOLD_OFF_CYCLES  = 240;
   localparam int MAX_REPORTS      = 10;
   localparam int IDLE_PCT         = 37;
   localparam int PHASES           = 9;
   localparam int RANDOM_PER_PHASE = 92;
   localparam int DIRECTED_ROWS    = 22;

   // Phases with special traffic shapes.
   localparam int PAUSE_PHASE   = 3;
   localparam int NO_IDLE_PHASE = 6;
   localparam int HOLD_PHASE    = 7;

   localparam int DEG_MAX   = (1 << (DEG_W - 1)) - 1;
   localparam int DEG_MIN   = -(1 << (DEG_W - 1));
   localparam int MILLI_TOP = (1 << MILLI_W) - 1;

   // Register indexes past the end of the limit file.
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = CSR_IDX_W'(LIMIT_COUNT);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP   = '1;

   typedef enum {HEAT_QUIET, HEAT_WARM, HEAT_HOT} heat_level_type;

   typedef enum {
      LIMITS_KEEP, LIMITS_TOP, LIMITS_BOTTOM, LIMITS_ORDERED, LIMITS_CROSSED, LIMITS_ANY
   } limit_plan_type;

   typedef struct packed {
      logic [MILLI_W-1:0]      digital_milli;
      logic                    digital_fail;
      logic [MILLI_W-1:0]      rf_milli;
      logic                    rf_fail;
      logic                    aux_present;
      logic                    aux_fail;
      logic signed [DEG_W-1:0] pa;
      logic signed [DEG_W-1:0] board;
      logic                    typed;
      thermal_state_type       state;
      logic                    changed;
      action_kind_type         action;
      alert_kind_type          alert;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tas_req_if req_bus ();
   tas_rsp_if rsp_bus ();
   tas_csr_if csr_bus ();

   thermal_alarm_state_machine uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // Directed checks, starting from reset limits (warning 70, critical 85).
   // Rows with typed set carry their expected result; the rest use the predictor.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NORMAL, 0, ACT_NONE, ALERT_NONE},
      '{70999, 0, 70999, 0, 1, 0, 70, 70, 1, ST_NORMAL, 0, ACT_NONE, ALERT_NONE},
      '{71000, 0, 0, 0, 0, 0, 0, 0, 1, ST_WARNING, 1, ACT_WARNING, ALERT_WARNING},
      '{0, 0, 85999, 0, 0, 0, 0, 0, 1, ST_WARNING, 0, ACT_NONE, ALERT_NONE},
      '{0, 0, 86000, 0, 0, 0, 0, 0, 1, ST_CRITICAL, 1, ACT_CRITICAL, ALERT_CRITICAL},
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, ST_WARNING, 1, ACT_WARNING, ALERT_WARNING},
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, ST_HYST, 1, ACT_NONE, ALERT_NONE},
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NORMAL, 1, ACT_NORMAL, ALERT_NONE},
      '{MILLI_TOP, 0, MILLI_TOP, 0, 0, 0, 0, 0, 1, ST_CRITICAL, 1, ACT_CRITICAL, ALERT_CRITICAL},
      '{0, 1, 0, 0, 0, 0, 0, 0, 1, ST_CRITICAL, 0, ACT_NONE, ALERT_NONE},
      '{0, 0, 0, 0, 0, 1, 255, 255, 1, ST_WARNING, 1, ACT_WARNING, ALERT_WARNING},
      '{0, 0, 0, 0, 1, 0, -256, -256, 1, ST_HYST, 1, ACT_NONE, ALERT_NONE},
      '{0, 0, 0, 0, 1, 0, 71, 0, 1, ST_WARNING, 1, ACT_WARNING, ALERT_WARNING},
      '{0, 0, 0, 0, 1, 0, 0, 255, 1, ST_CRITICAL, 1, ACT_CRITICAL, ALERT_CRITICAL},
      '{0, 0, 0, 0, 1, 0, -256, 85, 1, ST_CRITICAL, 0, ACT_NONE, ALERT_NONE},
      '{0, 0, MILLI_TOP, 1, 0, 0, 0, 0, 0, ST_NORMAL, 0, ACT_NONE, ALERT_NONE},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL, 0, ACT_NONE, ALERT_NONE},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL, 0, ACT_NONE, ALERT_NONE},
      '{0, 0, 0, 0, 1, 1, -256, -256, 0, ST_NORMAL, 0, ACT_NONE, ALERT_NONE},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL, 0, ACT_NONE, ALERT_NONE},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL, 0, ACT_NONE, ALERT_NONE},
      '{MILLI_TOP, 1, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL, 0, ACT_NONE, ALERT_NONE}
   };

   limit_plan_type phase_plan [PHASES] = '{
      LIMITS_KEEP, LIMITS_TOP, LIMITS_BOTTOM, LIMITS_ORDERED, LIMITS_CROSSED,
      LIMITS_ANY, LIMITS_ORDERED, LIMITS_ORDERED, LIMITS_ANY
   };

   // Predictor state: limit file and machine state as the block should hold them.
   logic signed [DEG_W-1:0] limit_deg [LIMIT_COUNT];
   thermal_state_type       alarm_state;
   rsp_payload_type         pending_results [$];

   int  req_idle_pct = IDLE_PCT;
   int  rsp_idle_pct = IDLE_PCT;
   bit  hold_off_req = 1'b0;
   int  hold_offs_done = 0;
   int  mismatches = 0;
   int  results_checked = 0;
   int  checks_sent = 0;
   int  state_changes = 0;
   int  state_hits [4] = '{0, 0, 0, 0};
   int  stall_cycles = 0;

   // Warning and critical conditions raised by one reading.
   function automatic cond_type over_limits(input int deg,
                                            input logic signed [DEG_W-1:0] warn_lim,
                                            input logic signed [DEG_W-1:0] crit_lim);
      cond_type c;
      c.warn = deg > warn_lim;
      c.crit = deg > crit_lim;
      return c;
   endfunction

   // Work out the result of one check request and advance the predicted state.
   function automatic rsp_payload_type advance_thermal(input req_payload_type chk);
      cond_type          c;
      thermal_state_type moved_state;
      rsp_payload_type   res;
      c = '0;
      if (chk.digital_fail) begin
         c = '1;
      end else begin
         c = c | over_limits(int'(chk.digital_millideg / MILLI_PER_DEG),
                             limit_deg[LIM_DIGITAL_WARN], limit_deg[LIM_DIGITAL_CRIT]);
      end
      if (chk.rf_fail) begin
         c = '1;
      end else begin
         c = c | over_limits(int'(chk.rf_millideg / MILLI_PER_DEG),
                             limit_deg[LIM_RF_WARN], limit_deg[LIM_RF_CRIT]);
      end
      // The auxiliary pair only counts when it was read this time.
      if (chk.aux_present) begin
         if (chk.aux_fail) begin
            c = '1;
         end else begin
            c = c | over_limits(int'($signed(chk.pa_degrees)),
                                limit_deg[LIM_PA_WARN], limit_deg[LIM_PA_CRIT]);
            c = c | over_limits(int'($signed(chk.board_degrees)),
                                limit_deg[LIM_BOARD_WARN], limit_deg[LIM_BOARD_CRIT]);
         end
      end

      moved_state = alarm_state;
      case (alarm_state)
         ST_NORMAL: begin
            if (c.crit) moved_state = ST_CRITICAL;
            else if (c.warn) moved_state = ST_WARNING;
         end
         ST_HYST: begin
            if (c.crit) moved_state = ST_CRITICAL;
            else if (c.warn) moved_state = ST_WARNING;
            else moved_state = ST_NORMAL;
         end
         ST_WARNING: begin
            if (c.crit) moved_state = ST_CRITICAL;
            else if (!c.warn) moved_state = ST_HYST;
         end
         default: begin
            if (!c.crit && !c.warn) moved_state = ST_WARNING;
         end
      endcase

      res.thermal_state = moved_state;
      res.state_changed = moved_state != alarm_state;
      res.action_kind   = ACT_NONE;
      res.alert_kind    = ALERT_NONE;
      // Actions and alerts follow the new state, and only on a move.
      if (res.state_changed) begin
         case (moved_state)
            ST_NORMAL: res.action_kind = ACT_NORMAL;
            ST_WARNING: begin
               res.action_kind = ACT_WARNING;
               res.alert_kind  = ALERT_WARNING;
            end
            ST_CRITICAL: begin
               res.action_kind = ACT_CRITICAL;
               res.alert_kind  = ALERT_CRITICAL;
            end
            default: ;
         endcase
      end
      alarm_state = moved_state;
      return res;
   endfunction

   // A reading in whole degrees placed just around the limits for the wanted heat.
   function automatic int near_degrees(input int warn_lim, input int crit_lim,
                                       input heat_level_type heat);
      case (heat)
         HEAT_QUIET: return (warn_lim < crit_lim ? warn_lim : crit_lim)
                            - int'($urandom_range(3));
         HEAT_WARM:  return warn_lim + 1 + int'($urandom_range(2));
         default:    return (warn_lim > crit_lim ? warn_lim : crit_lim)
                            + 1 + int'($urandom_range(3));
      endcase
   endfunction

   // The source chosen to carry the heat gets it; the others mostly stay quiet.
   function automatic heat_level_type source_heat(input heat_level_type heat, input bit chosen);
      if (chosen) return heat;
      if (heat == HEAT_QUIET || $urandom_range(3) != 0) return HEAT_QUIET;
      return heat_level_type'($urandom_range(2));
   endfunction

   function automatic logic [MILLI_W-1:0] to_millideg(input int deg);
      int m;
      if ($urandom_range(9) == 0) return MILLI_W'($urandom);
      if (deg < 0) deg = 0;
      m = deg * int'(MILLI_PER_DEG) + int'($urandom_range(int'(MILLI_PER_DEG) - 1));
      if (m > MILLI_TOP) m = MILLI_TOP;
      return MILLI_W'(m);
   endfunction

   function automatic logic [DEG_W-1:0] to_degrees(input int deg);
      if ($urandom_range(9) == 0) return DEG_W'($urandom);
      if (deg < DEG_MIN) deg = DEG_MIN;
      if (deg > DEG_MAX) deg = DEG_MAX;
      return DEG_W'(deg);
   endfunction

   // One random check request, aimed at the current limits.
   function automatic req_payload_type random_check(input heat_level_type heat);
      req_payload_type p;
      int              hot_source;
      hot_source = $urandom_range(3);
      p.digital_millideg = to_millideg(near_degrees(limit_deg[LIM_DIGITAL_WARN],
         limit_deg[LIM_DIGITAL_CRIT], source_heat(heat, hot_source == 0)));
      p.rf_millideg = to_millideg(near_degrees(limit_deg[LIM_RF_WARN],
         limit_deg[LIM_RF_CRIT], source_heat(heat, hot_source == 1)));
      p.pa_degrees = to_degrees(near_degrees(limit_deg[LIM_PA_WARN],
         limit_deg[LIM_PA_CRIT], source_heat(heat, hot_source == 2)));
      p.board_degrees = to_degrees(near_degrees(limit_deg[LIM_BOARD_WARN],
         limit_deg[LIM_BOARD_CRIT], source_heat(heat, hot_source == 3)));
      p.digital_fail = $urandom_range(31) == 0;
      p.rf_fail      = $urandom_range(31) == 0;
      p.aux_present  = 1'($urandom_range(1));
      p.aux_fail     = p.aux_present ? ($urandom_range(19) == 0) : 1'($urandom_range(1));
      return p;
   endfunction

   // Offer one check request, with random gaps, and record its expected result.
   task automatic drive_check(input req_payload_type chk, input bit typed,
                              input rsp_payload_type typed_result);
      rsp_payload_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.digital_millideg <= chk.digital_millideg;
      req_bus.digital_fail     <= chk.digital_fail;
      req_bus.rf_millideg      <= chk.rf_millideg;
      req_bus.rf_fail          <= chk.rf_fail;
      req_bus.aux_present      <= chk.aux_present;
      req_bus.aux_fail         <= chk.aux_fail;
      req_bus.pa_degrees       <= chk.pa_degrees;
      req_bus.board_degrees    <= chk.board_degrees;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = advance_thermal(chk);
      pending_results.push_back(typed ? typed_result : predicted);
      checks_sent++;
      @(negedge clock);
   endtask

   // Stop offering requests and wait until every expected result has come back.
   task automatic settle_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (RESULT_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input logic [DEG_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      // Writes past the limit file are dropped by the block.
      if (idx < LIMIT_COUNT) limit_deg[idx[LIMIT_IDX_W-1:0]] = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void flag_mismatch(input string what, input logic [1:0] want,
                                         input logic [1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("Result %0d: %s expected %0d, got %0d", results_checked, what, want, got);
   endfunction

   // Result receiver: random back-pressure, plus one long hold-off on request.
   initial begin : result_receiver
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(negedge clock);
            hold_off_req = 1'b0;
            hold_offs_done++;
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         @(negedge clock);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : result_checker
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Result with no check request outstanding: state %0d",
                        rsp_bus.thermal_state);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.thermal_state !== want.thermal_state)
               flag_mismatch("thermal_state", want.thermal_state, rsp_bus.thermal_state);
            if (rsp_bus.state_changed !== want.state_changed)
               flag_mismatch("state_changed", want.state_changed, rsp_bus.state_changed);
            if (rsp_bus.action_kind !== want.action_kind)
               flag_mismatch("action_kind", want.action_kind, rsp_bus.action_kind);
            if (rsp_bus.alert_kind !== want.alert_kind)
               flag_mismatch("alert_kind", want.alert_kind, rsp_bus.alert_kind);
            results_checked++;
            state_hits[want.thermal_state]++;
            if (want.state_changed) state_changes++;
         end
      end
   end

   // Watchdog on cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      directed_row_type   row;
      req_payload_type    chk;
      rsp_payload_type    typed_result;
      heat_level_type     heat;
      int                 burst_left;
      int                 warn_deg;
      int                 crit_deg;

      req_bus.valid            = 1'b0;
      req_bus.digital_millideg = '0;
      req_bus.digital_fail     = 1'b0;
      req_bus.rf_millideg      = '0;
      req_bus.rf_fail          = 1'b0;
      req_bus.aux_present      = 1'b0;
      req_bus.aux_fail         = 1'b0;
      req_bus.pa_degrees       = '0;
      req_bus.board_degrees    = '0;
      csr_bus.valid            = 1'b0;
      csr_bus.index            = '0;
      csr_bus.data             = '0;
      for (int i = 0; i < LIMIT_COUNT; i++) limit_deg[i] = LIMIT_RESET[i];
      alarm_state = ST_NORMAL;
      heat = HEAT_QUIET;
      burst_left = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table at the reset limits.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         chk = '{row.digital_milli, row.digital_fail, row.rf_milli, row.rf_fail,
                 row.aux_present, row.aux_fail, row.pa, row.board};
         typed_result = '{row.state, row.changed, row.action, row.alert};
         drive_check(chk, row.typed, typed_result);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         settle_results();

         // Reprogram the limits while the block is idle.
         if (phase_plan[phase] == LIMITS_KEEP) begin
            write_limit(CSR_IDX_SPARE, DEG_W'($urandom));
            write_limit(CSR_IDX_TOP, '1);
         end else begin
            // Warning limits sit at even indexes, critical ones just above.
            for (int i = 0; i < LIMIT_COUNT; i += 2) begin
               case (phase_plan[phase])
                  LIMITS_TOP: begin
                     warn_deg = DEG_MAX;
                     crit_deg = DEG_MAX;
                  end
                  LIMITS_BOTTOM: begin
                     warn_deg = DEG_MIN;
                     crit_deg = DEG_MIN;
                  end
                  LIMITS_ORDERED: begin
                     warn_deg = $urandom_range(110, 20);
                     crit_deg = warn_deg + int'($urandom_range(30, 1));
                  end
                  LIMITS_CROSSED: begin
                     warn_deg = $urandom_range(140, 40);
                     crit_deg = warn_deg - int'($urandom_range(30, 1));
                  end
                  default: begin
                     warn_deg = DEG_MIN + int'($urandom_range(DEG_MAX - DEG_MIN));
                     crit_deg = DEG_MIN + int'($urandom_range(DEG_MAX - DEG_MIN));
                  end
               endcase
               write_limit(CSR_IDX_W'(i), DEG_W'(warn_deg));
               write_limit(CSR_IDX_W'(i + 1), DEG_W'(crit_deg));
            end
         end

         // Traffic shape for this phase.
         req_idle_pct = (phase == NO_IDLE_PHASE || phase == HOLD_PHASE) ? 0 : IDLE_PCT;
         rsp_idle_pct = (phase == NO_IDLE_PHASE) ? 0 : IDLE_PCT;
         if (phase == HOLD_PHASE) hold_off_req = 1'b1;

         // Heat comes in short bursts so the machine walks through all its states.
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               heat = heat_level_type'($urandom_range(2));
               burst_left = $urandom_range(5, 1);
            end
            burst_left--;
            if (phase == PAUSE_PHASE && n == RANDOM_PER_PHASE / 2) settle_results();
            drive_check(random_check(heat), 1'b0, '0);
         end
      end

      settle_results();
      repeat (RESULT_LATENCY + 8) @(negedge clock);

      $display("Covered %0d check requests over %0d limit settings;",
               checks_sent, PHASES);
      $display("%0d results checked, %0d moves; by state: normal %0d, hysteresis %0d,",
               results_checked, state_changes, state_hits[ST_NORMAL], state_hits[ST_HYST]);
      $display("warning %0d, critical %0d; %0d hold-off.",
               state_hits[ST_WARNING], state_hits[ST_CRITICAL], hold_offs_done);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tas_pkg.sv
rtl/tas_intf.sv
rtl/tas_eval.sv
rtl/thermal_alarm_state_machine.sv
verif/tb_top.sv
